@@ rtl/core/wsfe_pkg.sv @@
package wsfe_pkg;

  // request kinds on the input channel
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // 7-bit length codes of the second header byte
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [63:0] LEN_SHORT_LIMIT = 64'd126;
  localparam logic [63:0] LEN_16_MAX      = 64'hFFFF;

  // extended length byte counts
  localparam logic [3:0] EXT_NONE = 4'd0;
  localparam logic [3:0] EXT_16   = 4'd2;
  localparam logic [3:0] EXT_64   = 4'd8;
  localparam logic [3:0] KEY_BYTES = 4'd4;

  // default depth of the command queue
  localparam int WSFE_QDEPTH = 4;

  // one classified command: a whole header, one ready payload byte, or one dropped stray byte
  typedef struct packed {
    logic [7:0]  b0;       // first byte (header byte 0 or payload byte)
    logic [7:0]  b1;       // mask bit and length code
    logic [3:0]  n_bytes;  // bytes this command emits, 1 to 14
    logic [3:0]  ext_n;    // extended length bytes, 0, 2 or 8
    logic [63:0] len;
    logic [31:0] key;
    logic        done;     // last byte completes the frame
    logic        stray;    // dropped payload byte
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ rtl/core/wsfe_ifs.sv @@
interface ws_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        fin_flag;
  logic [3:0]  opcode;
  logic        mask_enable;
  logic [31:0] mask_key;
  logic [63:0] payload_length;
  logic [7:0]  data_byte;

  modport source (
    output valid, req_type, fin_flag, opcode, mask_enable, mask_key,
           payload_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, fin_flag, opcode, mask_enable, mask_key,
           payload_length, data_byte,
    output ready
  );
endinterface

interface ws_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_done;
  logic       stray_error;

  modport source (
    output valid, out_byte, last_of_run, frame_done, stray_error,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_of_run, frame_done, stray_error,
    output ready
  );
endinterface

@@ rtl/core/wsfe_front.sv @@
module wsfe_front
  import wsfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  ws_in_if.sink    in_ch,
  input  q_stat_t  q_stat,
  output logic     push,
  output cmd_t     push_cmd
);

  logic        frame_open_r, frame_open_nxt;
  logic [63:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] key_r, key_nxt;
  logic        mask_r, mask_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  key_byte;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;
  assign key_byte    = mask_r ? key_r[{phase_r, 3'b000} +: 8] : 8'd0;

  always_comb begin
    push_cmd       = '0;
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    key_nxt        = key_r;
    mask_nxt       = mask_r;
    phase_nxt      = phase_r;
    if (in_ch.req_type == REQ_START) begin
      push_cmd.b0  = {in_ch.fin_flag, 3'b000, in_ch.opcode};
      push_cmd.len = in_ch.payload_length;
      push_cmd.key = in_ch.mask_key;
      if (in_ch.payload_length < LEN_SHORT_LIMIT) begin
        push_cmd.b1    = {in_ch.mask_enable, in_ch.payload_length[6:0]};
        push_cmd.ext_n = EXT_NONE;
      end else if (in_ch.payload_length <= LEN_16_MAX) begin
        push_cmd.b1    = {in_ch.mask_enable, LEN_CODE_16};
        push_cmd.ext_n = EXT_16;
      end else begin
        push_cmd.b1    = {in_ch.mask_enable, LEN_CODE_64};
        push_cmd.ext_n = EXT_64;
      end
      push_cmd.n_bytes = 4'd2 + push_cmd.ext_n + (in_ch.mask_enable ? KEY_BYTES : 4'd0);
      push_cmd.done    = (in_ch.payload_length == 64'd0);
      frame_open_nxt   = (in_ch.payload_length != 64'd0);
      bytes_left_nxt   = in_ch.payload_length;
      key_nxt          = in_ch.mask_key;
      mask_nxt         = in_ch.mask_enable;
      phase_nxt        = 2'd0;
    end else if (frame_open_r) begin
      push_cmd.b0      = in_ch.data_byte ^ key_byte;
      push_cmd.n_bytes = 4'd1;
      push_cmd.done    = (bytes_left_r == 64'd1);
      phase_nxt        = phase_r + 2'd1;
      bytes_left_nxt   = bytes_left_r - 64'd1;
      frame_open_nxt   = (bytes_left_r != 64'd1);
    end else begin
      // no open frame: drop the byte and flag it
      push_cmd.n_bytes = 4'd1;
      push_cmd.stray   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= '0;
      key_r        <= '0;
      mask_r       <= 1'b0;
      phase_r      <= '0;
    end else if (push) begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
      key_r        <= key_nxt;
      mask_r       <= mask_nxt;
      phase_r      <= phase_nxt;
    end
  end

endmodule

@@ rtl/core/wsfe_queue.sv @@
module wsfe_queue
  import wsfe_pkg::*;
#(
  parameter int QDEPTH = WSFE_QDEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  cmd_t                        push_cmd,
  input  logic                        pop,
  output cmd_t                        head,
  output q_stat_t                     q_stat,
  output logic [$clog2(QDEPTH+1)-1:0] count
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CW'(QDEPTH));
  assign count        = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/wsfe_back.sv @@
module wsfe_back
  import wsfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_t     head,
  input  q_stat_t  q_stat,
  output logic     pop,
  ws_out_if.source out_ch
);

  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       last_r, done_r, stray_r;

  logic       advance, fire, last;
  logic [3:0] pos;
  logic [2:0] len_sel;
  logic [1:0] key_sel;
  logic [7:0] byte_sel;

  assign advance = !out_valid_r || out_ch.ready;
  assign fire    = advance && !q_stat.empty;
  assign last    = (idx_r == head.n_bytes - 4'd1);
  assign pop     = fire && last;

  // pick the byte at idx_r of the current command
  always_comb begin
    pos     = idx_r - 4'd2;
    len_sel = 3'(head.ext_n - 4'd1 - pos);
    key_sel = 2'(pos - head.ext_n);
    if (idx_r == 4'd0) begin
      byte_sel = head.b0;
    end else if (idx_r == 4'd1) begin
      byte_sel = head.b1;
    end else if (pos < head.ext_n) begin
      byte_sel = head.len[{len_sel, 3'b000} +: 8];
    end else begin
      byte_sel = head.key[{key_sel, 3'b000} +: 8];
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = '0;
    end else if (fire) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (advance) begin
        out_valid_r <= !q_stat.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= byte_sel;
      last_r     <= last;
      done_r     <= last && head.done;
      stray_r    <= head.stray;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.frame_done  = done_r;
  assign out_ch.stray_error = stray_r;

endmodule

@@ rtl/core/websocket_frame_encoder.sv @@
// path: the bytes of an accepted item pass through the command queue, then the registered output stage
// throughput: one output byte per cycle while the receiver is ready; a payload item yields one byte, a start 2 to 14
// the front takes one item per cycle while the command queue has room
// reset: synchronous, active low; clears frame state, queue pointers and output valid
module websocket_frame_encoder
  import wsfe_pkg::*;
#(
  parameter int QDEPTH = WSFE_QDEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  ws_in_if.sink    in_ch,
  ws_out_if.source out_ch
);

  localparam int CW = $clog2(QDEPTH + 1);

  // front to queue
  logic    push;
  cmd_t    push_cmd;
  // queue to back
  logic    pop;
  cmd_t    head;
  q_stat_t q_stat;
  logic [CW-1:0] q_count;

  // front: tracks the open frame, classifies each item into a command,
  // masks payload bytes and decides frame end and stray bytes
  wsfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // short queue that decouples item intake from byte output
  wsfe_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat),
    .count    (q_count)
  );

  // back: walks the header bytes of a start or emits one payload or stray byte,
  // into a registered output stage
  wsfe_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // frame end only on the last byte of an item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_done |-> out_ch.last_of_run)
    else $error("frame_done without last_of_run");

  // a dropped byte gives a single zero result that ends nothing
  a_stray_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.stray_error |->
      out_ch.last_of_run && !out_ch.frame_done && (out_ch.out_byte == 8'd0))
    else $error("malformed stray result");

  // queue never over- or underflows
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_count != '0))
    else $error("pop from empty queue");

endmodule

@@ dv/wsfe_checker.sv @@
module wsfe_checker
  import wsfe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ws_in_if     in_ch,
  ws_out_if    out_ch,
  output int   fail_count,
  output int   pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       stray;
  } enc_byte_t;

  enc_byte_t exp_bytes[$];
  int fails;

  // encoder state of the open frame
  logic [63:0] remaining;
  logic [31:0] frame_key;
  logic        mask_on;
  logic [1:0]  key_idx;
  logic        open_frame;

  // expected bytes for one accepted item
  function automatic void encode_item(logic req, logic fin, logic [3:0] op, logic men,
                                      logic [31:0] key, logic [63:0] len,
                                      logic [7:0] data);
    logic [7:0] hdr [14];
    int n;
    enc_byte_t e;
    n = 0;
    if (req == REQ_START) begin
      hdr[0] = {fin, 3'b000, op};
      n = 1;
      if (len < LEN_SHORT_LIMIT) begin
        hdr[1] = {men, len[6:0]};
        n = 2;
      end else if (len <= LEN_16_MAX) begin
        hdr[1] = {men, LEN_CODE_16};
        hdr[2] = len[15:8];
        hdr[3] = len[7:0];
        n = 4;
      end else begin
        hdr[1] = {men, LEN_CODE_64};
        n = 2;
        for (int i = 7; i >= 0; i--) begin
          hdr[n] = len[8*i +: 8];
          n++;
        end
      end
      if (men) begin
        for (int i = 0; i < 4; i++) begin
          hdr[n] = key[8*i +: 8];
          n++;
        end
      end
      remaining  = len;
      frame_key  = key;
      mask_on    = men;
      key_idx    = 2'd0;
      open_frame = (len != 64'd0);
      for (int i = 0; i < n; i++) begin
        e.data  = hdr[i];
        e.last  = (i == n - 1);
        e.done  = (i == n - 1) && (len == 64'd0);
        e.stray = 1'b0;
        exp_bytes.push_back(e);
      end
    end else if (!open_frame) begin
      // dropped byte
      e = '{data: 8'h00, last: 1'b1, done: 1'b0, stray: 1'b1};
      exp_bytes.push_back(e);
    end else begin
      e.data  = mask_on ? (data ^ frame_key[8*key_idx +: 8]) : data;
      key_idx = key_idx + 2'd1;
      remaining = remaining - 64'd1;
      e.last  = 1'b1;
      e.done  = (remaining == 64'd0);
      e.stray = 1'b0;
      if (e.done) open_frame = 1'b0;
      exp_bytes.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    enc_byte_t got;
    enc_byte_t want;
    if (!rst_n) begin
      exp_bytes.delete();
      remaining  = '0;
      frame_key  = '0;
      mask_on    = 1'b0;
      key_idx    = 2'd0;
      open_frame = 1'b0;
      fails      = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        encode_item(in_ch.req_type, in_ch.fin_flag, in_ch.opcode, in_ch.mask_enable,
                    in_ch.mask_key, in_ch.payload_length, in_ch.data_byte);
      if (out_ch.valid && out_ch.ready) begin
        got = '{data: out_ch.out_byte, last: out_ch.last_of_run,
                done: out_ch.frame_done, stray: out_ch.stray_error};
        if (exp_bytes.size() == 0) begin
          $display("%0t: expected none, got byte=%02h last=%b done=%b stray=%b",
                   $time, got.data, got.last, got.done, got.stray);
          fails++;
        end else begin
          want = exp_bytes.pop_front();
          if (got !== want) begin
            $display("%0t: expected %02h l=%b d=%b s=%b, got %02h l=%b d=%b s=%b",
                     $time, want.data, want.last, want.done, want.stray,
                     got.data, got.last, got.done, got.stray);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= exp_bytes.size();
  end

endmodule

@@ dv/tb.sv @@
module tb;
  import wsfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 430;
  localparam int DRAIN_CYCLES = 60;
  // worst case is far below this: 14 bytes per start with long receiver stalls
  localparam int CYCLE_LIMIT = 300000;

  // one input item as the sender sees it
  typedef struct packed {
    logic        req_type;
    logic        fin;
    logic [3:0]  opcode;
    logic        men;
    logic [31:0] key;
    logic [63:0] len;
    logic [7:0]  data;
  } ws_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ws_in_if  in_ch ();
  ws_out_if out_ch ();

  int fail_count;
  int pending;
  int items_sent = 0;
  int cycle_count = 0;
  int idle_pct = 0;     // chance in a hundred that the sender idles a cycle
  int stall_pct = 0;    // chance in a hundred that the receiver stalls a cycle

  websocket_frame_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wsfe_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random back-pressure, one decision per cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog, counts from time zero so it covers reset as well
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("websocket_frame_encoder: mismatch");
      $finish;
    end
  end

  // fully random item, every field and bit free
  function automatic ws_req_t rand_req();
    ws_req_t r;
    r.req_type = 1'($urandom_range(1));
    r.fin      = 1'($urandom_range(1));
    r.opcode   = 4'($urandom_range(15));
    r.men      = 1'($urandom_range(1));
    r.key      = $urandom;
    r.len      = {$urandom, $urandom};
    r.data     = 8'($urandom_range(255));
    return r;
  endfunction

  // present one item and hold it until the block takes it;
  // valid stays high between back-to-back items
  task automatic send(input ws_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= r.req_type;
    in_ch.fin_flag       <= r.fin;
    in_ch.opcode         <= r.opcode;
    in_ch.mask_enable    <= r.men;
    in_ch.mask_key       <= r.key;
    in_ch.payload_length <= r.len;
    in_ch.data_byte      <= r.data;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // frame start; data_byte left random since the block ignores it
  task automatic send_start(input logic fin, input logic [3:0] op, input logic men,
                            input logic [31:0] key, input logic [63:0] len);
    ws_req_t r;
    r = rand_req();
    r.req_type = REQ_START;
    r.fin      = fin;
    r.opcode   = op;
    r.men      = men;
    r.key      = key;
    r.len      = len;
    send(r);
  endtask

  // payload byte; header fields left random since the block ignores them
  task automatic send_byte(input logic [7:0] b);
    ws_req_t r;
    r = rand_req();
    r.req_type = REQ_DATA;
    r.data     = b;
    send(r);
  endtask

  initial begin
    int len;
    int cut;
    int pick;
    int phase;
    int base;
    logic [63:0] long_len;

    // input channel known from time zero
    in_ch.valid          <= 1'b0;
    in_ch.req_type       <= REQ_START;
    in_ch.fin_flag       <= 1'b0;
    in_ch.opcode         <= 4'd0;
    in_ch.mask_enable    <= 1'b0;
    in_ch.mask_key       <= '0;
    in_ch.payload_length <= '0;
    in_ch.data_byte      <= '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling on either side

    // payload byte with no frame open right after reset: dropped
    send_byte(8'hFF);
    // empty frames: header only, done on the last header byte
    send_start(1'b1, 4'd1, 1'b0, 32'h0, 64'd0);
    send_start(1'b1, 4'd2, 1'b1, 32'hDEADBEEF, 64'd0);
    // longest short length, then abandoned by the next start
    send_start(1'b0, 4'd2, 1'b0, 32'h0, 64'd125);
    send_byte(8'h00);
    send_byte(8'hFF);
    // smallest 16-bit length, masked
    send_start(1'b1, 4'd8, 1'b1, 32'hFFFFFFFF, 64'd126);
    send_byte(8'h5A);
    // largest 16-bit length and smallest 64-bit length
    send_start(1'b1, 4'd9, 1'b0, 32'h0, 64'hFFFF);
    send_start(1'b0, 4'd10, 1'b0, 32'h0, 64'h10000);
    // all-ones length, reserved opcode, top length bit set
    send_start(1'b1, 4'd15, 1'b1, 32'h01020304, 64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'hA5);
    // complete masked frame, key phase wraps past byte 3
    send_start(1'b0, 4'd0, 1'b1, 32'hA55A_C33C, 64'd5);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
    send_byte(8'h9A);
    // frame closed again, so this one is dropped
    send_byte(8'h00);
    // one-byte unmasked frame
    send_start(1'b1, 4'd1, 1'b0, 32'h0, 64'd1);
    send_byte(8'hC3);
    send_byte(8'h3C);

    // random part in four idling phases
    base = items_sent;
    while (items_sent - base < RAND_ITEMS) begin
      phase = (items_sent - base) * 4 / RAND_ITEMS;
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 55;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 55;
        end
        default: begin
          idle_pct = 17;
          stall_pct <= 17;
        end
      endcase

      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed frame, mostly short, sometimes cut off early
        len = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(10);
        cut = ($urandom_range(9) == 0) ? $urandom_range(len) : len;
        send_start(1'($urandom_range(1)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                   $urandom, 64'(len));
        for (int k = 0; k < cut; k++)
          send_byte(8'($urandom_range(255)));
      end else if (pick < 85) begin
        // long frame: header forms for large lengths, a few bytes, left open
        case ($urandom_range(3))
          0: long_len = 64'd126 + 64'($urandom_range(65535 - 126));
          1: long_len = 64'h10000 + 64'($urandom);
          2: long_len = {$urandom, $urandom};
          default: begin
            case ($urandom_range(4))
              0: long_len = 64'd125;
              1: long_len = 64'd126;
              2: long_len = 64'hFFFF;
              3: long_len = 64'h10000;
              default: long_len = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
          end
        endcase
        send_start(1'($urandom_range(1)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                   $urandom, long_len);
        cut = $urandom_range(5);
        for (int k = 0; k < cut; k++)
          send_byte(8'($urandom_range(255)));
      end else begin
        // noise: random items, mostly payload bytes that may land outside a frame
        cut = $urandom_range(1, 3);
        for (int k = 0; k < cut; k++) begin
          if ($urandom_range(2) == 0)
            send(rand_req());
          else
            send_byte(8'($urandom_range(255)));
        end
      end
    end

    in_ch.valid <= 1'b0;

    // wait out every expected byte, then give stray extras time to show up
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("websocket_frame_encoder: match");
    else
      $display("websocket_frame_encoder: mismatch");
    $finish;
  end

endmodule
